FILE: rtl/gvw_pkg.sv
// Package: shared constants and types for the grid vertex weld block.
`default_nettype none
package gvw_pkg;
	localparam int unsigned MaxVertices  = 4096;
	localparam int unsigned MaxParticles = 4096;
	localparam int unsigned CellSizeRst  = 100;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_VERTEX = 2'd1;
	localparam logic [1:0] ACT_FACE   = 2'd2;

	localparam logic [1:0] FLT_NONE   = 2'd0;
	localparam logic [1:0] FLT_FULL   = 2'd1;
	localparam logic [1:0] FLT_UNSEEN = 2'd2;

	// one cell key: rounded grid cell on all three axes
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} cell_key_t;
endpackage
`default_nettype wire

FILE: rtl/gvw_div_cell.sv
// Module: one restoring-division cell; handles one quotient bit per cycle for three axes.
`default_nettype none
module gvw_div_cell
	import gvw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] mag_in [3],
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [32:0]      quo [3]
);
	logic [5:0]  cnt_q;
	logic [31:0] num_q [3];
	logic [16:0] rem_q [3];
	logic [31:0] qb_q  [3];
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift one numerator bit into each remainder, subtract when it fits
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (start) begin
				num_q[a] <= mag_in[a];
				rem_q[a] <= '0;
				qb_q[a]  <= '0;
			end else if (cnt_q != 6'd0) begin
				logic [17:0] t;
				t = {rem_q[a], num_q[a][31]};
				num_q[a] <= {num_q[a][30:0], 1'b0};
				if (t >= {2'b0, divisor}) begin
					rem_q[a] <= 17'(t - {2'b0, divisor});
					qb_q[a]  <= {qb_q[a][30:0], 1'b1};
				end else begin
					rem_q[a] <= t[16:0];
					qb_q[a]  <= {qb_q[a][30:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			// round half away from zero on magnitude
			quo[a] = {1'b0, qb_q[a]} +
				33'(({rem_q[a], 1'b0} >= {2'b0, divisor}) ? 1 : 0);
		end
	end
	assign done = done_q;
endmodule
`default_nettype wire

FILE: rtl/gvw_key_cell.sv
// Module: one cell of the key chain; holds one stored particle and compares the key passing by.
`default_nettype none
module gvw_key_cell
	import gvw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      wr_en,
	input  wire cell_key_t wr_key,
	input  wire logic      live,
	input  wire cell_key_t probe,
	output logic           hit
);
	cell_key_t key_q;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr_key;
		end
	end
	assign hit = live && (key_q == probe);
endmodule
`default_nettype wire

FILE: rtl/grid_vertex_weld.sv
// Module: top level of the grid vertex weld block.
// Usage:
//  - in channel (in_valid/in_ready) carries one word per item: action,
//    position, inverse mass and face source indices.
//  - out channel (out_valid/out_ready) returns one word per item.
//  - cfg channel (cfg_valid/cfg_ready) writes cell_size; write it only
//    while idle. A zero cell size acts as one.
//  - One item is worked at a time. A vertex passes the bit-serial divider
//    cell (one quotient bit per cycle for all three axes), a check of the
//    vertex store, then the match over the row of key cells, which runs
//    one slice of 256 particle cells per cycle and stops at the first hit,
//    then a memory read, a memory write and the output register. A full
//    vertex store answers after the vertex store check, a full particle
//    store after a match with no hit. Faces make three lookups in turn
//    through the one read port of the vertex map memory. Clear, unknown
//    actions and faces with unseen indices go straight to the output register.
//  - Reset clears counts, cell_size returns to 100, no clearing pass runs:
//    only entries below the counts are ever used.
//  - When the receiver stalls, the result is held in the output register
//    and in_ready stays low; the next item is accepted in the cycle after
//    the word is taken.
`default_nettype none
module grid_vertex_weld
	import gvw_pkg::*;
#(
	parameter int unsigned MAX_VERTICES  = MaxVertices,
	parameter int unsigned MAX_PARTICLES = MaxParticles
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [15:0]        inv_mass,
	input  wire logic [11:0]        src_a,
	input  wire logic [11:0]        src_b,
	input  wire logic [11:0]        src_c,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [11:0]             particle,
	output logic                    is_new,
	output logic [15:0]             mass_now,
	output logic [11:0]             face_a,
	output logic [11:0]             face_b,
	output logic [11:0]             face_c,
	output logic                    face_kept,
	output logic [1:0]              fault,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cell_size
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int PW = $clog2(MAX_PARTICLES);
	localparam int SLICE = (MAX_PARTICLES < 256) ? MAX_PARTICLES : 256;
	localparam int NSL = (MAX_PARTICLES + SLICE - 1) / SLICE;
	localparam int SW = (NSL > 1) ? $clog2(NSL) : 1;
	localparam int LW = $clog2(SLICE);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_DIV = 4'd1, ST_KEY = 4'd2,
		ST_SCAN = 4'd3, ST_MRD = 4'd4, ST_MWR = 4'd5, ST_FA = 4'd6,
		ST_FB = 4'd7, ST_FC = 4'd8, ST_FD = 4'd9, ST_OUT = 4'd10;

	logic [3:0]  st_q;
	logic [15:0] cs_q;
	logic [VW:0] vcnt_q;
	logic [PW:0] pcnt_q;
	logic [15:0] mass_q;
	logic [2:0]  neg_q;
	logic [11:0] sa_q, sb_q, sc_q;
	cell_key_t   key_q;
	logic [SW-1:0] sl_q;
	logic        found_q;
	logic [PW-1:0] hit_idx_q;

	// hold output word
	logic        ov_q;
	logic [11:0] part_q, fa_q, fb_q, fc_q;
	logic        new_q, kept_q;
	logic [15:0] mn_q;
	logic [1:0]  flt_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == ST_IDLE) && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= 16'(CellSizeRst);
		end else if (cfg_valid) begin
			cs_q <= cell_size;
		end
	end
	wire [15:0] cs_eff = (cs_q == 16'd0) ? 16'd1 : cs_q;

	// divider cell
	logic        dv_start, dv_done;
	logic [31:0] dv_mag [3];
	logic [32:0] dv_quo [3];
	always_comb begin
		dv_mag[0] = pos_x[31] ? 32'(-pos_x) : pos_x;
		dv_mag[1] = pos_y[31] ? 32'(-pos_y) : pos_y;
		dv_mag[2] = pos_z[31] ? 32'(-pos_z) : pos_z;
	end
	assign dv_start = in_valid && in_ready && (action == ACT_VERTEX);
	gvw_div_cell u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .mag_in(dv_mag),
		.divisor(cs_eff), .done(dv_done), .quo(dv_quo)
	);

	// row of key cells
	logic [MAX_PARTICLES-1:0] hits;
	logic kw_en;
	generate
		for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
			gvw_key_cell u_cell (
				.clk(clk),
				.wr_en(kw_en && (pcnt_q[PW-1:0] == PW'(i))),
				.wr_key(key_q),
				.live((PW+1)'(i) < pcnt_q),
				.probe(key_q),
				.hit(hits[i])
			);
		end
	endgenerate

	// slice search: first hit within current slice
	logic [NSL*SLICE-1:0] hits_pad;
	logic [SLICE-1:0]     seg;
	logic                 sl_hit;
	logic [LW-1:0]        sl_idx;
	assign hits_pad = (NSL*SLICE)'(hits);
	assign seg      = hits_pad[int'(sl_q) * SLICE +: SLICE];
	always_comb begin
		sl_hit = 1'b0;
		sl_idx = '0;
		for (int j = SLICE - 1; j >= 0; j--) begin
			if (seg[j]) begin
				sl_hit = 1'b1;
				sl_idx = LW'(j);
			end
		end
	end

	// memories
	logic [15:0]   pmass_mem [MAX_PARTICLES];
	logic [11:0]   v2p_mem   [MAX_VERTICES];
	logic [15:0]   pm_rd;
	logic [11:0]   v2p_rd;
	logic [VW-1:0] v_raddr;
	logic          pm_we, v_we;
	logic [15:0]   pm_wd;
	logic [PW-1:0] pm_addr;
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pmass_mem[pm_addr] <= pm_wd;
		end
		pm_rd <= pmass_mem[pm_addr];
	end
	always_ff @(posedge clk) begin
		if (v_we) begin
			v2p_mem[vcnt_q[VW-1:0]] <= 12'(pm_addr);
		end
		v2p_rd <= v2p_mem[v_raddr];
	end

	wire         pfull  = (pcnt_q >= (PW+1)'(MAX_PARTICLES));
	wire         vfull  = (vcnt_q >= (VW+1)'(MAX_VERTICES));
	wire [15:0]  m_min  = (mass_q < pm_rd) ? mass_q : pm_rd;
	always_comb begin
		pm_addr = found_q ? hit_idx_q : pcnt_q[PW-1:0];
		pm_we   = (st_q == ST_MWR);
		pm_wd   = found_q ? m_min : mass_q;
		v_we    = (st_q == ST_MWR);
		kw_en   = (st_q == ST_MWR) && !found_q;
		case (st_q)
			ST_FA:   v_raddr = VW'(sa_q);
			ST_FB:   v_raddr = VW'(sb_q);
			default: v_raddr = VW'(sc_q);
		endcase
	end

	function automatic logic in_range(input logic [11:0] s, input logic [VW:0] n);
		in_range = (32'(s) < 32'(n));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			vcnt_q    <= '0;
			pcnt_q    <= '0;
			ov_q      <= 1'b0;
			part_q    <= '0;
			new_q     <= 1'b0;
			mn_q      <= '0;
			fa_q      <= '0;
			fb_q      <= '0;
			fc_q      <= '0;
			kept_q    <= 1'b0;
			flt_q     <= FLT_NONE;
			mass_q    <= '0;
			neg_q     <= '0;
			sa_q      <= '0;
			sb_q      <= '0;
			sc_q      <= '0;
			key_q     <= '0;
			sl_q      <= '0;
			found_q   <= 1'b0;
			hit_idx_q <= '0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						part_q <= '0; new_q <= 1'b0; mn_q <= '0;
						fa_q <= '0; fb_q <= '0; fc_q <= '0;
						kept_q <= 1'b0; flt_q <= FLT_NONE;
						mass_q <= inv_mass;
						neg_q  <= {pos_z[31], pos_y[31], pos_x[31]};
						sa_q <= src_a; sb_q <= src_b; sc_q <= src_c;
						case (action)
							ACT_CLEAR: begin
								vcnt_q <= '0;
								pcnt_q <= '0;
								st_q   <= ST_OUT;
							end
							ACT_VERTEX: st_q <= ST_DIV;
							ACT_FACE: begin
								if (in_range(src_a, vcnt_q) && in_range(src_b, vcnt_q)
									&& in_range(src_c, vcnt_q)) begin
									st_q <= ST_FA;
								end else begin
									flt_q <= FLT_UNSEEN;
									st_q  <= ST_OUT;
								end
							end
							default: st_q <= ST_OUT;
						endcase
					end
				end
				ST_DIV: begin
					if (dv_done) begin
						key_q.x <= neg_q[0] ? 32'(-dv_quo[0]) : dv_quo[0][31:0];
						key_q.y <= neg_q[1] ? 32'(-dv_quo[1]) : dv_quo[1][31:0];
						key_q.z <= neg_q[2] ? 32'(-dv_quo[2]) : dv_quo[2][31:0];
						st_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					sl_q    <= '0;
					found_q <= 1'b0;
					if (vfull) begin
						flt_q <= FLT_FULL;
						st_q  <= ST_OUT;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance one slice per cycle, stop at first hit
					if (sl_hit) begin
						found_q   <= 1'b1;
						hit_idx_q <= PW'(int'(sl_q) * SLICE + int'(sl_idx));
						st_q      <= ST_MRD;
					end else if (int'(sl_q) == NSL - 1) begin
						if (pfull) begin
							flt_q <= FLT_FULL;
							st_q  <= ST_OUT;
						end else begin
							st_q <= ST_MRD;
						end
					end else begin
						sl_q <= sl_q + SW'(1);
					end
				end
				ST_MRD: st_q <= ST_MWR;
				ST_MWR: begin
					part_q <= 12'(pm_addr);
					new_q  <= !found_q;
					mn_q   <= pm_wd;
					vcnt_q <= vcnt_q + (VW+1)'(1);
					if (!found_q) begin
						pcnt_q <= pcnt_q + (PW+1)'(1);
					end
					st_q <= ST_OUT;
				end
				ST_FA: st_q <= ST_FB;
				ST_FB: begin
					fa_q <= v2p_rd;
					st_q <= ST_FC;
				end
				ST_FC: begin
					fb_q <= v2p_rd;
					st_q <= ST_FD;
				end
				ST_FD: begin
					fc_q   <= v2p_rd;
					kept_q <= (fa_q != fb_q) && (fb_q != v2p_rd) && (fa_q != v2p_rd);
					st_q   <= ST_OUT;
				end
				ST_OUT: begin
					ov_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign particle  = part_q;
	assign is_new    = new_q;
	assign mass_now  = mn_q;
	assign face_a    = fa_q;
	assign face_b    = fb_q;
	assign face_c    = fc_q;
	assign face_kept = kept_q;
	assign fault     = flt_q;
endmodule
`default_nettype wire

FILE: rtl/gvw_checker.sv
// Module: port-level checker for the grid vertex weld block, with its bind.
`default_nettype none
module gvw_checker
	import gvw_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] fault,
	input wire logic       face_kept,
	input wire logic       is_new
);
	// a held result word stays valid until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out dropped");
	// no new item while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while pending");
	// a faulted word carries no flags
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault != FLT_NONE) |-> !face_kept && !is_new)
		else $error("fault word not clean");
	// an accept is not directly followed by a valid result word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind grid_vertex_weld gvw_checker u_gvw_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .fault(fault),
	.face_kept(face_kept), .is_new(is_new)
);
`default_nettype wire
